/* sv/deadline_ordered_timer_table_top_assert.svh */
// Assertion macros used by the timer table datapath.
`ifndef DEADLINE_ORDERED_TIMER_TABLE_TOP_ASSERT_SVH
`define DEADLINE_ORDERED_TIMER_TABLE_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define DOTT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("timer table check failed");

// Check a property on every clock edge, reset included.
`define DOTT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("timer table check failed");

`endif

/* sv/dott_pkg.sv */
// Shared constants and types of the timer table.
`timescale 1ns / 1ps
package dott_pkg;
    localparam int SLOTS = 16;
    localparam int SW    = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int TW    = 64;
    localparam int CW    = 3;
    localparam int IDW   = 4;
    localparam int WW    = 32;
    localparam logic [WW-1:0] WINDOW_RST = 32'd3600000;

    localparam logic [CW-1:0] CMD_ADD     = 3'd0;
    localparam logic [CW-1:0] CMD_CANCEL  = 3'd1;
    localparam logic [CW-1:0] CMD_REFRESH = 3'd2;
    localparam logic [CW-1:0] CMD_RESET   = 3'd3;
    localparam logic [CW-1:0] CMD_EXPIRE  = 3'd4;
    localparam logic [CW-1:0] CMD_QUERY   = 3'd5;

    typedef enum logic [2:0] {
        K_NONE, K_FRONT, K_MARK, K_MIN, K_SEL
    } t_kind;

    typedef enum logic [3:0] {
        ST_NONE, ST_LATCH, ST_PREP, ST_EXEC, ST_SCAN,
        ST_AFTER, ST_RARM_RD, ST_RARM, ST_EMIT
    } t_step;

    typedef struct packed {
        t_step         step;
        logic [SW-1:0] idx;
    } t_ctl;

    typedef struct packed {
        t_kind kind;
        logic  any_mark;
        logic  out_free;
    } t_sts;
endpackage

/* sv/dott_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module dott_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 16
) (
    input  logic                                        i_clk,
    input  logic                                        i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                            i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                            o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* sv/dott_ctrl.sv */
// Command sequencer of the timer table.
`timescale 1ns / 1ps
module dott_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    input  dott_pkg::t_sts i_sts,
    output dott_pkg::t_ctl o_ctl
);
    import dott_pkg::*;

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_PREP  = 9'b000000010,
        S_EXEC  = 9'b000000100,
        S_ROUTE = 9'b000001000,
        S_SCAN  = 9'b000010000,
        S_DRAIN = 9'b000100000,
        S_AFTER = 9'b001000000,
        S_RD    = 9'b010000000,
        S_EMIT  = 9'b100000000
    } t_state;

    t_state        r_state, n_state;
    logic [SW-1:0] r_idx, n_idx;
    logic          r_rearm, n_rearm;

    always_comb begin
        n_state    = r_state;
        n_idx      = r_idx;
        n_rearm    = 1'b0;
        o_ctl.step = ST_NONE;
        o_ctl.idx  = r_idx;
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_ctl.step = ST_LATCH;
                    n_state    = S_PREP;
                end
            end
            S_PREP: begin
                o_ctl.step = ST_PREP;
                n_state    = S_EXEC;
            end
            S_EXEC: begin
                o_ctl.step = ST_EXEC;
                n_state    = S_ROUTE;
            end
            S_ROUTE: begin
                n_idx   = '0;
                n_state = (i_sts.kind == K_NONE) ? S_EMIT : S_SCAN;
            end
            S_SCAN: begin
                o_ctl.step = ST_SCAN;
                if (r_idx == SW'(SLOTS - 1)) begin
                    n_state = S_DRAIN;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DRAIN: begin
                n_state = S_AFTER;
            end
            S_AFTER: begin
                o_ctl.step = ST_AFTER;
                n_idx      = '0;
                case (i_sts.kind)
                    K_MARK:  n_state = i_sts.any_mark ? S_SCAN : S_EMIT;
                    K_SEL:   n_state = S_RD;
                    default: n_state = S_EMIT;
                endcase
            end
            S_RD: begin
                // read the interval first, then re-arm or drop the slot
                if (r_rearm) begin
                    o_ctl.step = ST_RARM;
                    n_state    = S_EMIT;
                end else begin
                    o_ctl.step = ST_RARM_RD;
                    n_rearm    = 1'b1;
                end
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_ctl.step = ST_EMIT;
                    n_idx      = '0;
                    n_state    = (i_sts.kind == K_SEL && i_sts.any_mark) ? S_SCAN : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
            r_rearm <= 1'b0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_rearm <= n_rearm;
        end
    end

    assign o_stall = (r_state != S_IDLE);
endmodule

/* sv/dott_dp.sv */
// Slot storage, scan compare and result register of the timer table.
`timescale 1ns / 1ps
`include "deadline_ordered_timer_table_top_assert.svh"
module dott_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  dott_pkg::t_ctl           i_ctl,
    output dott_pkg::t_sts           o_sts,
    input  logic                     i_cfg_we,
    input  logic [dott_pkg::WW-1:0]  i_cfg_data,
    input  logic [dott_pkg::CW-1:0]  i_command,
    input  logic [dott_pkg::IDW-1:0] i_slot_id,
    input  logic [dott_pkg::TW-1:0]  i_interval,
    input  logic                     i_repeat_mode,
    input  logic                     i_start_from_now,
    input  logic [dott_pkg::TW-1:0]  i_now_time,
    input  logic                     i_stall,
    output logic                     o_valid,
    output logic [dott_pkg::IDW-1:0] o_result_slot,
    output logic                     o_success,
    output logic                     o_expired_valid,
    output logic                     o_last_of_run,
    output logic [dott_pkg::TW-1:0]  o_time_to_next,
    output logic                     o_front_notice,
    output logic                     o_any_armed
);
    import dott_pkg::*;

    // latched command
    logic [CW-1:0]  r_cmd;
    logic [IDW-1:0] r_sid;
    logic [TW-1:0]  r_ivl, r_now, r_tgt_d, r_best_d, r_prev_now;
    logic           r_rep, r_fromnow, r_free;
    logic [SW-1:0]  r_tgt, r_best, r_si;
    logic [WW-1:0]  r_window;
    logic           r_notice, r_roll, r_best_v, r_front_ok, r_sv, r_final_any;
    logic [SLOTS-1:0] r_armed, r_rec, r_mark;
    t_kind          r_kind;

    // pending result
    logic [IDW-1:0] r_res_slot;
    logic           r_res_succ, r_res_exp, r_res_last, r_res_front;
    logic [TW-1:0]  r_res_ttn;

    // output register
    logic           r_ovalid;
    logic [IDW-1:0] r_o_slot;
    logic           r_o_succ, r_o_exp, r_o_last, r_o_front, r_o_any;
    logic [TW-1:0]  r_o_ttn;

    logic           free_found;
    logic [SW-1:0]  free_idx;
    logic           sid_ok, tgt_armed, same_reset, cand, ahead;
    logic [TW-1:0]  rd_dl, rd_ivl, old_ivl, dl_base, dl_add, dl_wdata;
    logic           dl_we, ivl_we;
    logic [SW-1:0]  raddr, waddr;
    logic [SLOTS-1:0] best_hot;

    always_comb begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOTS - 1; i >= 0; i--) begin
            if (!r_armed[i]) begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    assign sid_ok     = (32'(r_sid) < SLOTS);
    assign tgt_armed  = r_armed[r_tgt] && ((r_cmd == CMD_ADD) || sid_ok);
    assign old_ivl    = sid_ok ? rd_ivl : '0;
    assign same_reset = (r_ivl == old_ivl) && !r_fromnow;
    assign best_hot   = SLOTS'(1) << r_best;

    // deadline write: base plus interval, shared by add, refresh, reset and re-arm
    always_comb begin
        dl_we   = 1'b0;
        ivl_we  = 1'b0;
        waddr   = r_tgt;
        dl_base = r_now;
        dl_add  = r_ivl;
        case (i_ctl.step)
            ST_EXEC: begin
                case (r_cmd)
                    CMD_ADD: begin
                        dl_we  = r_free;
                        ivl_we = r_free;
                    end
                    CMD_REFRESH: begin
                        dl_we  = tgt_armed;
                        dl_add = rd_ivl;
                    end
                    CMD_RESET: begin
                        dl_we  = tgt_armed && !same_reset;
                        ivl_we = tgt_armed && !same_reset;
                        if (!r_fromnow) begin
                            dl_base = rd_dl - old_ivl;
                        end
                    end
                    default: ;
                endcase
            end
            ST_RARM: begin
                waddr  = r_best;
                dl_we  = r_rec[r_best];
                dl_add = rd_ivl;
            end
            default: ;
        endcase
        dl_wdata = dl_base + dl_add;
    end

    always_comb begin
        case (i_ctl.step)
            ST_SCAN:    raddr = i_ctl.idx;
            ST_RARM_RD: raddr = r_best;
            default:    raddr = r_tgt;
        endcase
    end

    dott_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_dl_ram (
        .i_clk   (i_clk),
        .i_we    (dl_we),
        .i_waddr (waddr),
        .i_wdata (dl_wdata),
        .i_raddr (raddr),
        .o_rdata (rd_dl)
    );

    dott_ram #(.WIDTH(TW), .DEPTH(SLOTS)) u_ivl_ram (
        .i_clk   (i_clk),
        .i_we    (ivl_we),
        .i_waddr (waddr),
        .i_wdata (r_ivl),
        .i_raddr (raddr),
        .o_rdata (rd_ivl)
    );

    assign cand  = (r_kind == K_SEL) ? r_mark[r_si] : r_armed[r_si];
    // target stays ahead of the scanned slot in (deadline, slot) order
    assign ahead = (r_tgt_d < rd_dl) || ((r_tgt_d == rd_dl) && (r_tgt < r_si));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_armed    <= '0;
            r_mark     <= '0;
            r_prev_now <= '0;
            r_notice   <= 1'b0;
            r_window   <= WINDOW_RST;
            r_kind     <= K_NONE;
            r_sv       <= 1'b0;
            r_best_v   <= 1'b0;
            r_ovalid   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_window <= i_cfg_data;
            end
            if (!i_stall && (i_ctl.step != ST_EMIT)) begin
                r_ovalid <= 1'b0;
            end
            r_sv <= (i_ctl.step == ST_SCAN);
            r_si <= i_ctl.idx;

            if (r_sv) begin
                case (r_kind)
                    K_FRONT: begin
                        if (r_armed[r_si] && (r_si != r_tgt) && !ahead) begin
                            r_front_ok <= 1'b0;
                        end
                    end
                    K_MARK: r_mark[r_si] <= r_armed[r_si] && (r_roll || rd_dl <= r_now);
                    default: begin
                        if (cand && (!r_best_v || rd_dl < r_best_d)) begin
                            r_best_v <= 1'b1;
                            r_best   <= r_si;
                            r_best_d <= rd_dl;
                        end
                    end
                endcase
            end

            case (i_ctl.step)
                ST_LATCH: begin
                    r_cmd     <= i_command;
                    r_sid     <= i_slot_id;
                    r_ivl     <= i_interval;
                    r_rep     <= i_repeat_mode;
                    r_fromnow <= i_start_from_now;
                    r_now     <= i_now_time;
                    r_free    <= free_found;
                    r_tgt     <= (i_command == CMD_ADD) ? free_idx : SW'(i_slot_id);
                    r_kind    <= K_NONE;
                end
                ST_EXEC: begin
                    r_res_exp   <= 1'b0;
                    r_res_last  <= 1'b1;
                    r_res_ttn   <= '0;
                    r_res_front <= 1'b0;
                    r_res_succ  <= 1'b0;
                    r_res_slot  <= '0;
                    r_kind      <= K_NONE;
                    case (r_cmd)
                        CMD_ADD: begin
                            if (r_free) begin
                                r_armed[r_tgt] <= 1'b1;
                                r_rec[r_tgt]   <= r_rep;
                                r_tgt_d        <= dl_wdata;
                                r_res_succ     <= 1'b1;
                                r_res_slot     <= IDW'(r_tgt);
                                r_kind         <= r_notice ? K_NONE : K_FRONT;
                            end
                        end
                        CMD_CANCEL: begin
                            r_res_slot <= r_sid;
                            r_res_succ <= tgt_armed;
                            if (tgt_armed) begin
                                r_armed[r_tgt] <= 1'b0;
                            end
                        end
                        CMD_REFRESH: begin
                            r_res_slot <= r_sid;
                            r_res_succ <= tgt_armed;
                        end
                        CMD_RESET: begin
                            r_res_slot <= r_sid;
                            if (same_reset) begin
                                r_res_succ <= 1'b1;
                            end else begin
                                r_res_succ <= tgt_armed;
                                r_tgt_d    <= dl_wdata;
                                if (tgt_armed && !r_notice) begin
                                    r_kind <= K_FRONT;
                                end
                            end
                        end
                        CMD_EXPIRE: begin
                            if (|r_armed) begin
                                r_roll     <= (r_now < r_prev_now) &&
                                              (r_now < r_prev_now - TW'(r_window));
                                r_prev_now <= r_now;
                                r_kind     <= K_MARK;
                            end
                        end
                        CMD_QUERY: begin
                            r_notice <= 1'b0;
                            r_kind   <= K_MIN;
                        end
                        default: ;
                    endcase
                end
                ST_SCAN: begin
                    if (i_ctl.idx == '0) begin
                        r_best_v   <= 1'b0;
                        r_front_ok <= 1'b1;
                    end
                end
                ST_AFTER: begin
                    case (r_kind)
                        K_FRONT: begin
                            if (r_front_ok) begin
                                r_notice    <= 1'b1;
                                r_res_front <= 1'b1;
                            end
                            r_kind <= K_NONE;
                        end
                        K_MARK: begin
                            // every marked slot is reported, so the final armed set is known now
                            r_final_any <= |(r_armed & ~(r_mark & ~r_rec));
                            r_kind      <= (|r_mark) ? K_SEL : K_NONE;
                        end
                        K_MIN: begin
                            r_res_succ <= 1'b1;
                            if (!r_best_v) begin
                                r_res_ttn <= '1;
                            end else if (r_now >= r_best_d) begin
                                r_res_ttn <= '0;
                            end else begin
                                r_res_ttn <= r_best_d - r_now;
                            end
                            r_kind <= K_NONE;
                        end
                        default: ;
                    endcase
                end
                ST_RARM: begin
                    if (!r_rec[r_best]) begin
                        r_armed[r_best] <= 1'b0;
                    end
                    r_mark[r_best] <= 1'b0;
                    r_res_slot     <= IDW'(r_best);
                    r_res_succ     <= 1'b1;
                    r_res_exp      <= 1'b1;
                    r_res_last     <= ((r_mark & ~best_hot) == '0);
                end
                ST_EMIT: begin
                    r_ovalid  <= 1'b1;
                    r_o_slot  <= r_res_slot;
                    r_o_succ  <= r_res_succ;
                    r_o_exp   <= r_res_exp;
                    r_o_last  <= r_res_last;
                    r_o_ttn   <= r_res_ttn;
                    r_o_front <= r_res_front;
                    r_o_any   <= (r_kind == K_SEL) ? r_final_any : |r_armed;
                end
                default: ;
            endcase
        end
    end

    assign o_sts.kind     = r_kind;
    assign o_sts.any_mark = |r_mark;
    assign o_sts.out_free = !r_ovalid || !i_stall;

    assign o_valid         = r_ovalid;
    assign o_result_slot   = r_o_slot;
    assign o_success       = r_o_succ;
    assign o_expired_valid = r_o_exp;
    assign o_last_of_run   = r_o_last;
    assign o_time_to_next  = r_o_ttn;
    assign o_front_notice  = r_o_front;
    assign o_any_armed     = r_o_any;

    `DOTT_ASSERT(a_mark_armed, ((r_mark & ~r_armed) == '0))
    `DOTT_ASSERT(a_emit_loads, (i_ctl.step == ST_EMIT) |=> o_valid)
    `DOTT_ASSERT(a_exp_success, o_valid && o_expired_valid |-> o_success && !o_front_notice)
endmodule

/* sv/deadline_ordered_timer_table_top.sv */
// Top level of the deadline-ordered timer table.
`timescale 1ns / 1ps
// Sixteen timer slots kept in two small RAMs (deadline, interval) with armed and
// recurring bits in flops. One command is worked at a time. Add, cancel, refresh and
// reset run without a slot scan, but an add or reset that may raise the front notice
// adds one slot scan; a query scans every slot once; an expire does no scan with no
// slot armed, and else one scan to mark the due slots and one more per reported slot.
// Scans are bound by the single read port of the deadline RAM, which every scan walks
// one slot per cycle. A finished result waits in the output register while the next
// command is taken.
module deadline_ordered_timer_table_top (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [dott_pkg::WW-1:0]  i_cfg_data,
    input  logic                     i_valid,
    output logic                     o_stall,
    input  logic [dott_pkg::CW-1:0]  i_command,
    input  logic [dott_pkg::IDW-1:0] i_slot_id,
    input  logic [dott_pkg::TW-1:0]  i_interval,
    input  logic                     i_repeat_mode,
    input  logic                     i_start_from_now,
    input  logic [dott_pkg::TW-1:0]  i_now_time,
    output logic                     o_valid,
    input  logic                     i_stall,
    output logic [dott_pkg::IDW-1:0] o_result_slot,
    output logic                     o_success,
    output logic                     o_expired_valid,
    output logic                     o_last_of_run,
    output logic [dott_pkg::TW-1:0]  o_time_to_next,
    output logic                     o_front_notice,
    output logic                     o_any_armed
);
    import dott_pkg::*;

    t_ctl ctl;
    t_sts sts;

    dott_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    dott_dp u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_ctl            (ctl),
        .o_sts            (sts),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_data       (i_cfg_data),
        .i_command        (i_command),
        .i_slot_id        (i_slot_id),
        .i_interval       (i_interval),
        .i_repeat_mode    (i_repeat_mode),
        .i_start_from_now (i_start_from_now),
        .i_now_time       (i_now_time),
        .i_stall          (i_stall),
        .o_valid          (o_valid),
        .o_result_slot    (o_result_slot),
        .o_success        (o_success),
        .o_expired_valid  (o_expired_valid),
        .o_last_of_run    (o_last_of_run),
        .o_time_to_next   (o_time_to_next),
        .o_front_notice   (o_front_notice),
        .o_any_armed      (o_any_armed)
    );
endmodule

/* bench/dott_checker.sv */
// Timer table checker: predicts command results and compares the result stream.
`timescale 1ns / 1ps
module dott_checker (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [dott_pkg::WW-1:0]  i_cfg_data,
    input  logic                     i_valid,
    input  logic                     i_stall,
    input  logic [dott_pkg::CW-1:0]  i_command,
    input  logic [dott_pkg::IDW-1:0] i_slot_id,
    input  logic [dott_pkg::TW-1:0]  i_interval,
    input  logic                     i_repeat_mode,
    input  logic                     i_start_from_now,
    input  logic [dott_pkg::TW-1:0]  i_now_time,
    input  logic                     i_res_valid,
    input  logic                     i_res_stall,
    input  logic [dott_pkg::IDW-1:0] i_res_slot,
    input  logic                     i_res_success,
    input  logic                     i_res_expired,
    input  logic                     i_res_last,
    input  logic [dott_pkg::TW-1:0]  i_res_ttn,
    input  logic                     i_res_front,
    input  logic                     i_res_any_armed,
    output int                       o_errors,
    output int                       o_pending,
    output int                       o_checked,
    output logic [dott_pkg::SLOTS-1:0] o_written
);
    import dott_pkg::*;

    typedef struct packed {
        logic [IDW-1:0] slot;
        logic           ok;
        logic           expired;
        logic           last;
        logic [TW-1:0]  ttn;
        logic           front;
        logic           armed;
    } t_timer_res;

    t_timer_res      due_q[$];
    logic [SLOTS-1:0] armed_q, recur_q, written_q;
    logic [TW-1:0]   deadline_q[SLOTS];
    logic [TW-1:0]   period_q[SLOTS];
    logic [TW-1:0]   last_now_q;
    logic            notice_q;
    logic [WW-1:0]   window_q;
    int              errors, checked;

    assign o_errors  = errors;
    assign o_pending = due_q.size();
    assign o_checked = checked;
    assign o_written = written_q;

    function automatic logic earlier(int a, int b);
        if (deadline_q[a] != deadline_q[b]) return deadline_q[a] < deadline_q[b];
        return a < b;
    endfunction

    function automatic logic notice_for(int s);
        for (int i = 0; i < SLOTS; i++)
            if (i != s && armed_q[i] && !earlier(s, i)) return 1'b0;
        if (notice_q) return 1'b0;
        notice_q = 1'b1;
        return 1'b1;
    endfunction

    task automatic post(int slot, logic ok, logic expired, logic last,
                        logic [TW-1:0] ttn, logic front);
        t_timer_res r;
        r.slot    = slot[IDW-1:0];
        r.ok      = ok;
        r.expired = expired;
        r.last    = last;
        r.ttn     = ttn;
        r.front   = front;
        r.armed   = |armed_q;
        due_q     = {due_q, r};
    endtask

    task automatic run_command(logic [CW-1:0] cmd, int sid, logic [TW-1:0] ivl,
                               logic rep, logic restart, logic [TW-1:0] now);
        int            order[$];
        int            best;
        logic [SLOTS-1:0] mark;
        logic          roll, ok, f;
        logic [TW-1:0] old, ttn;
        case (cmd)
            CMD_ADD: begin
                best = -1;
                for (int i = SLOTS - 1; i >= 0; i--)
                    if (!armed_q[i]) best = i;
                if (best < 0) begin
                    post(0, 1'b0, 1'b0, 1'b1, '0, 1'b0);
                end else begin
                    armed_q[best]    = 1'b1;
                    written_q[best]  = 1'b1;
                    period_q[best]   = ivl;
                    recur_q[best]    = rep;
                    deadline_q[best] = now + ivl;
                    f = notice_for(best);
                    post(best, 1'b1, 1'b0, 1'b1, '0, f);
                end
            end
            CMD_CANCEL: begin
                ok = armed_q[sid];
                if (ok) armed_q[sid] = 1'b0;
                post(sid, ok, 1'b0, 1'b1, '0, 1'b0);
            end
            CMD_REFRESH: begin
                ok = armed_q[sid];
                if (ok) deadline_q[sid] = now + period_q[sid];
                post(sid, ok, 1'b0, 1'b1, '0, 1'b0);
            end
            CMD_RESET: begin
                old = period_q[sid];
                f   = 1'b0;
                if (!restart && ivl == old) begin
                    post(sid, 1'b1, 1'b0, 1'b1, '0, 1'b0);
                end else begin
                    ok = armed_q[sid];
                    if (ok) begin
                        deadline_q[sid] = (restart ? now : deadline_q[sid] - old) + ivl;
                        period_q[sid]   = ivl;
                        f = notice_for(sid);
                    end
                    post(sid, ok, 1'b0, 1'b1, '0, f);
                end
            end
            CMD_EXPIRE: begin
                if (armed_q == '0) begin
                    post(0, 1'b0, 1'b0, 1'b1, '0, 1'b0);
                end else begin
                    roll = now < last_now_q && now < last_now_q - TW'(window_q);
                    last_now_q = now;
                    for (int i = 0; i < SLOTS; i++)
                        mark[i] = armed_q[i] && (roll || deadline_q[i] <= now);
                    // pick in (deadline, slot) order
                    while (order.size() < 16) begin
                        best = -1;
                        for (int i = 0; i < SLOTS; i++)
                            if (mark[i] && (best < 0 || earlier(i, best))) best = i;
                        if (best < 0) break;
                        mark[best] = 1'b0;
                        order = {order, best};
                    end
                    if (order.size() == 0) begin
                        post(0, 1'b0, 1'b0, 1'b1, '0, 1'b0);
                    end else begin
                        foreach (order[k]) begin
                            if (recur_q[order[k]])
                                deadline_q[order[k]] = now + period_q[order[k]];
                            else
                                armed_q[order[k]] = 1'b0;
                        end
                        foreach (order[k])
                            post(order[k], 1'b1, 1'b1, k == order.size() - 1, '0, 1'b0);
                    end
                end
            end
            CMD_QUERY: begin
                notice_q = 1'b0;
                ttn  = '1;
                best = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (armed_q[i] && (best < 0 || earlier(i, best))) best = i;
                if (best >= 0)
                    ttn = (now >= deadline_q[best]) ? '0 : deadline_q[best] - now;
                post(0, 1'b1, 1'b0, 1'b1, ttn, 1'b0);
            end
            default: begin
                post(0, 1'b0, 1'b0, 1'b1, '0, 1'b0);
            end
        endcase
    endtask

    always @(posedge i_clk) begin
        t_timer_res want, got;
        if (!i_rst_n) begin
            armed_q    = '0;
            recur_q    = '0;
            written_q  = '0;
            last_now_q = '0;
            notice_q   = 1'b0;
            window_q   = WINDOW_RST;
            for (int i = 0; i < SLOTS; i++) begin
                deadline_q[i] = '0;
                period_q[i]   = '0;
            end
            due_q.delete();
            errors  = 0;
            checked = 0;
        end else begin
            if (i_res_valid && !i_res_stall) begin
                got = '{i_res_slot, i_res_success, i_res_expired, i_res_last,
                        i_res_ttn, i_res_front, i_res_any_armed};
                checked++;
                if (due_q.size() == 0) begin
                    errors++;
                    if (errors <= 10)
                        $display("unexpected result: slot=%0d ok=%0b exp=%0b last=%0b",
                                 got.slot, got.ok, got.expired, got.last);
                end else begin
                    want = due_q.pop_front();
                    if (got !== want) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("mismatch: expected slot=%0d ok=%0b exp=%0b last=%0b ttn=%h front=%0b armed=%0b",
                                     want.slot, want.ok, want.expired, want.last,
                                     want.ttn, want.front, want.armed);
                            $display("          got      slot=%0d ok=%0b exp=%0b last=%0b ttn=%h front=%0b armed=%0b",
                                     got.slot, got.ok, got.expired, got.last,
                                     got.ttn, got.front, got.armed);
                        end
                    end
                end
            end
            if (i_cfg_we) window_q = i_cfg_data;
            if (i_valid && !i_stall)
                run_command(i_command, int'(i_slot_id), i_interval, i_repeat_mode,
                            i_start_from_now, i_now_time);
        end
    end
endmodule

/* bench/tb.sv */
// Testbench top: drives commands and register writes into the timer table.
`timescale 1ns / 1ps
module tb;
    import dott_pkg::*;

    localparam logic [CW-1:0] CMD_SPARE_LO = 3'd6;
    localparam logic [CW-1:0] CMD_SPARE_HI = 3'd7;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [WW-1:0]       cfg_data = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [CW-1:0]       command = '0;
    logic [IDW-1:0]      slot_id = '0;
    logic [TW-1:0]       interval = '0;
    logic                repeat_mode = 1'b0;
    logic                start_from_now = 1'b0;
    logic [TW-1:0]       now_time = '0;
    logic                res_valid;
    logic                res_stall = 1'b0;
    logic [IDW-1:0]      res_slot;
    logic                res_success, res_expired, res_last, res_front, res_any_armed;
    logic [TW-1:0]       res_ttn;

    int                  errors, pending, checked;
    logic [SLOTS-1:0]    written;
    logic [TW-1:0]       now_t = 64'd1000;
    int                  sent = 0;
    logic                calm = 1'b0;
    logic                hold_req = 1'b0;

    always #10 i_clk = ~i_clk;

    deadline_ordered_timer_table_top u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .o_stall(in_stall),
        .i_command(command), .i_slot_id(slot_id), .i_interval(interval),
        .i_repeat_mode(repeat_mode), .i_start_from_now(start_from_now),
        .i_now_time(now_time),
        .o_valid(res_valid), .i_stall(res_stall),
        .o_result_slot(res_slot), .o_success(res_success),
        .o_expired_valid(res_expired), .o_last_of_run(res_last),
        .o_time_to_next(res_ttn), .o_front_notice(res_front),
        .o_any_armed(res_any_armed)
    );

    dott_checker u_check (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_cfg_we(cfg_we), .i_cfg_data(cfg_data),
        .i_valid(in_valid), .i_stall(in_stall),
        .i_command(command), .i_slot_id(slot_id), .i_interval(interval),
        .i_repeat_mode(repeat_mode), .i_start_from_now(start_from_now),
        .i_now_time(now_time),
        .i_res_valid(res_valid), .i_res_stall(res_stall),
        .i_res_slot(res_slot), .i_res_success(res_success),
        .i_res_expired(res_expired), .i_res_last(res_last),
        .i_res_ttn(res_ttn), .i_res_front(res_front),
        .i_res_any_armed(res_any_armed),
        .o_errors(errors), .o_pending(pending), .o_checked(checked),
        .o_written(written)
    );

    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 60) return 0;
        if (r < 94) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [TW-1:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // receiver: random stalls, or one long counted hold on request
    initial begin
        int left;
        int hold;
        bit held;
        left = 0;
        held = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_req && !held) begin
                hold = 400;
                while (hold > 0) begin
                    res_stall <= 1'b1;
                    hold--;
                    @(negedge i_clk);
                end
                held = 1'b1;
            end
            if (calm) begin
                res_stall <= 1'b0;
            end else if (left > 0) begin
                left--;
            end else begin
                left = $urandom_range(0, 99);
                if (left < 60) begin
                    res_stall <= 1'b0;
                    left = $urandom_range(0, 8);
                end else if (left < 95) begin
                    res_stall <= 1'b1;
                    left = $urandom_range(0, 2);
                end else begin
                    res_stall <= 1'b1;
                    left = $urandom_range(10, 40);
                end
            end
        end
    end

    task automatic send(logic [CW-1:0] cmd, int sid, logic [TW-1:0] ivl,
                        logic rep, logic restart, logic [TW-1:0] now);
        int g;
        g = gap_len();
        if (g > 0) begin
            in_valid <= 1'b0;
            repeat (g) @(negedge i_clk);
        end
        in_valid       <= 1'b1;
        command        <= cmd;
        slot_id        <= sid[IDW-1:0];
        interval       <= ivl;
        repeat_mode    <= rep;
        start_from_now <= restart;
        now_time       <= now;
        do @(posedge i_clk); while (in_stall);
        sent++;
        @(negedge i_clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (20) @(negedge i_clk);
    endtask

    task automatic write_window(logic [WW-1:0] value);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge i_clk);
        cfg_we   <= 1'b0;
    endtask

    task automatic random_item();
        int            r, sid;
        logic [CW-1:0] cmd;
        logic [TW-1:0] ivl;
        logic          restart;
        r   = $urandom_range(0, 99);
        sid = ($urandom_range(0, 99) < 80) ? $urandom_range(0, 7) : $urandom_range(0, 15);
        ivl = ($urandom_range(0, 99) < 85) ? TW'($urandom_range(0, 120)) : rand64();
        restart = 1'($urandom_range(0, 1));
        // advance time, with the odd backward jump or wild value
        r = $urandom_range(0, 99);
        if (r < 3) now_t = now_t - TW'($urandom_range(0, 8000000));
        else if (r < 4) now_t = rand64();
        else now_t = now_t + TW'($urandom_range(0, 40));
        r = $urandom_range(0, 99);
        if (r < 30) cmd = CMD_ADD;
        else if (r < 45) cmd = CMD_EXPIRE;
        else if (r < 55) cmd = CMD_QUERY;
        else if (r < 63) cmd = CMD_CANCEL;
        else if (r < 72) cmd = CMD_REFRESH;
        else if (r < 88) cmd = CMD_RESET;
        else cmd = CMD_ADD;
        if (r >= 94) begin
            // noise: any command, any fields
            cmd = CW'($urandom_range(0, 7));
            ivl = rand64();
        end
        if (cmd == CMD_RESET && !written[sid]) restart = 1'b1;
        send(cmd, sid, ivl, 1'($urandom_range(0, 1)), restart,
             (r >= 94) ? rand64() : now_t);
    endtask

    initial begin
        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // opening checks at the reset window
        send(CMD_QUERY,   0, '0, 1'b0, 1'b0, 64'd1000);
        send(CMD_EXPIRE,  0, '0, 1'b0, 1'b0, 64'd1000);
        send(CMD_CANCEL, 15, '0, 1'b0, 1'b0, 64'd1000);
        send(CMD_ADD,     0, 64'd0, 1'b1, 1'b0, 64'd1000);
        send(CMD_ADD,     0, '1, 1'b0, 1'b0, 64'd1000);
        send(CMD_ADD,     0, 64'd100, 1'b0, 1'b0, 64'd1000);
        send(CMD_QUERY,   0, '0, 1'b0, 1'b0, 64'd990);
        send(CMD_ADD,     0, 64'd50, 1'b1, 1'b0, 64'd900);
        send(CMD_RESET,   2, 64'd100, 1'b0, 1'b0, 64'd1005);
        send(CMD_RESET,   2, 64'd30, 1'b0, 1'b0, 64'd1005);
        send(CMD_RESET,   3, 64'd5, 1'b0, 1'b1, 64'd1010);
        send(CMD_REFRESH, 1, '0, 1'b0, 1'b0, 64'd1010);
        send(CMD_CANCEL,  1, '0, 1'b0, 1'b0, 64'd1010);
        send(CMD_REFRESH, 1, '0, 1'b0, 1'b0, 64'd1010);
        send(CMD_RESET,   9, 64'd7, 1'b1, 1'b1, 64'd1010);
        send(CMD_SPARE_LO, 15, '1, 1'b1, 1'b1, '1);
        send(CMD_SPARE_HI, 15, '1, 1'b1, 1'b1, '1);
        send(CMD_EXPIRE,  0, '0, 1'b0, 1'b0, 64'd1100);
        send(CMD_QUERY,   0, '0, 1'b0, 1'b0, 64'd1100);
        send(CMD_EXPIRE,  0, '0, 1'b0, 1'b0, 64'd10);
        drain();

        // zero window: fill the table, overflow it, then jump back
        write_window('0);
        for (int i = 0; i < 17; i++)
            send(CMD_ADD, 0, TW'($urandom_range(0, 500)), 1'($urandom_range(0, 1)), 1'b0,
                 64'd5000);
        send(CMD_EXPIRE, 0, '0, 1'b0, 1'b0, 64'd4999);
        now_t = 64'd6000;
        repeat (50) random_item();
        drain();

        // widest window, with a long hold on the result side
        write_window('1);
        hold_req = 1'b1;
        repeat (50) random_item();
        drain();

        write_window(WW'($urandom));
        calm = 1'b1;
        repeat (35) random_item();
        calm = 1'b0;
        drain();

        write_window(WINDOW_RST);
        repeat (35) random_item();
        drain();
        repeat (50) @(posedge i_clk);

        $display("covered %0d commands and %0d checked results", sent, checked);
        $display("window settings: reset value, zero, all ones, random; long result hold");
        if (errors == 0 && pending == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("%0d mismatches, %0d results outstanding", errors, pending);
            $display("RESULT: ERROR");
        end
        $finish;
    end

    initial begin
        #40_000_000;
        $display("timeout with %0d results outstanding", pending);
        $display("RESULT: ERROR");
        $finish;
    end
endmodule
